// ===== design/pdcch_dmrs_generator_assert.svh =====
// assertion macros used by the checker file
`ifndef PDCCH_DMRS_GENERATOR_ASSERT_SVH
`define PDCCH_DMRS_GENERATOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PDMRS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define PDMRS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/pdmrs_pkg.sv =====
// types, constants and codes shared by the dmrs generator modules
package pdmrs_pkg;

    // sizing
    localparam int MAX_CORESET_RBS = 256;
    localparam int RE_PER_RB       = 3;
    localparam int GOLD_DISCARD    = 1600;
    localparam int BITS_PER_RB     = 2 * RE_PER_RB;

    localparam int RB_ADDR_W = $clog2(MAX_CORESET_RBS);
    localparam int RB_CNT_W  = $clog2(MAX_CORESET_RBS + 1);
    localparam int DISC_W    = $clog2(GOLD_DISCARD + 2);
    localparam int BIT_CNT_W = $clog2(BITS_PER_RB);
    localparam int RE_IDX_W  = $clog2(RE_PER_RB);

    // field widths
    localparam int SCR_ID_W   = 16;
    localparam int SLOT_W     = 9;
    localparam int START_W    = 4;
    localparam int CSYM_W     = 2;
    localparam int CRBS_W     = 9;
    localparam int OFFSET_W   = 2;
    localparam int RB_IDX_W   = 8;
    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // c_init arithmetic: only the low 14 bits of the product survive mod 2^31
    localparam int LFSR_W     = 31;
    localparam int CINIT_SH   = 17;
    localparam int CINIT_HI_W = LFSR_W - CINIT_SH;
    localparam int SYM_A_W    = 13;
    localparam int SYMS_PER_SLOT = 14;

    // qpsk amplitudes, q15
    localparam logic signed [SAMPLE_W-1:0] POS_AMP = 16'sd23170;
    localparam logic signed [SAMPLE_W-1:0] NEG_AMP = -16'sd23170;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCRAMBLING_ID = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_NUMBER   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SYMBOL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CORESET_SYMS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CORESET_RBS   = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_CALC_A,
        ST_CALC_P,
        ST_SEED,
        ST_DISCARD,
        ST_FILL,
        ST_READ,
        ST_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic                accept;
        logic                calc_a;
        logic                calc_p;
        logic                seed;
        logic                discard;
        logic                fill;
        logic                rd;
        logic                emit;
        logic [RE_IDX_W-1:0] re_idx;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic regen;
        logic err;
        logic disc_done;
        logic fill_done;
        logic out_free;
    } sts_t;

endpackage

// ===== design/pdmrs_ctrl.sv =====
// sequencer for acceptance, sequence regeneration and re output
module pdmrs_ctrl import pdmrs_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t              state_reg, state_next;
    logic [RE_IDX_W-1:0] k_reg, k_next;

    // state and re counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        cmd        = '0;
        cmd.re_idx = k_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (sts.regen) begin
                    state_next = ST_CALC_A;
                end else if (sts.err) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_CALC_A: begin
                cmd.calc_a = 1'b1;
                state_next = ST_CALC_P;
            end
            ST_CALC_P: begin
                cmd.calc_p = 1'b1;
                state_next = ST_SEED;
            end
            ST_SEED: begin
                cmd.seed   = 1'b1;
                state_next = ST_DISCARD;
            end
            ST_DISCARD: begin
                if (sts.disc_done) begin
                    state_next = ST_FILL;
                end else begin
                    cmd.discard = 1'b1;
                end
            end
            ST_FILL: begin
                if (sts.fill_done) begin
                    state_next = sts.err ? ST_EMIT : ST_READ;
                end else begin
                    cmd.fill = 1'b1;
                end
            end
            ST_READ: begin
                cmd.rd     = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (k_reg == RE_IDX_W'(RE_PER_RB - 1)) begin
                        k_next     = '0;
                        state_next = ST_IDLE;
                    end else begin
                        k_next = k_reg + RE_IDX_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/pdmrs_datapath.sv =====
// config registers, gold sequence lfsrs, bit store and output word register
module pdmrs_datapath import pdmrs_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    // config writes
    input  logic                   cfg_valid,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input word fields
    input  logic [OFFSET_W-1:0]    in_offset,
    input  logic [RB_IDX_W-1:0]    in_rb,
    input  logic                   in_first,
    // controller link
    input  cmd_t                   cmd,
    output sts_t                   sts,
    // output word
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [2*SAMPLE_W-1:0]  m_tdata,
    output logic                   m_tlast,
    output logic [0:0]             m_tuser
);

    // config registers
    logic [SCR_ID_W-1:0] scr_id_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [START_W-1:0]  start_reg;
    logic [CSYM_W-1:0]   csyms_reg;
    logic [CRBS_W-1:0]   crbs_reg;

    // held input word
    logic [OFFSET_W-1:0] off_reg;
    logic [RB_IDX_W-1:0] rb_reg;
    logic                first_reg;

    // c_init pipeline
    logic [SYM_A_W-1:0]    a_reg;
    logic [CINIT_HI_W-1:0] p_reg;

    // gold generator
    logic [LFSR_W-1:0]    x1_reg, x2_reg;
    logic [LFSR_W-1:0]    x1_next, x2_next;
    logic                 gold_bit;
    logic [DISC_W-1:0]    disc_cnt_reg;
    logic [RB_CNT_W-1:0]  rb_cnt_reg;
    logic [BIT_CNT_W-1:0] bit_cnt_reg;
    logic [BITS_PER_RB-1:0] shift_reg;

    // bit store, one word of six bits per rb
    logic [BITS_PER_RB-1:0] store_mem [0:MAX_CORESET_RBS-1];
    logic [BITS_PER_RB-1:0] rd_word_reg;

    // output register
    logic                       m_tvalid_reg, m_tvalid_next;
    logic signed [SAMPLE_W-1:0] re_reg, im_reg;
    logic                       last_reg, err_reg;

    logic [RB_CNT_W-1:0]  rb_count;
    logic                 bad_sym;
    logic                 bad_rb;
    logic [BIT_CNT_W-1:0] re_sel;

    // config write decode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scr_id_reg <= '0;
            slot_reg   <= '0;
            start_reg  <= '0;
            csyms_reg  <= CSYM_W'(1);
            crbs_reg   <= CRBS_W'(1);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SCRAMBLING_ID: scr_id_reg <= cfg_data[SCR_ID_W-1:0];
                CFG_SLOT_NUMBER:   slot_reg   <= cfg_data[SLOT_W-1:0];
                CFG_START_SYMBOL:  start_reg  <= cfg_data[START_W-1:0];
                CFG_CORESET_SYMS:  csyms_reg  <= cfg_data[CSYM_W-1:0];
                CFG_CORESET_RBS:   crbs_reg   <= cfg_data[CRBS_W-1:0];
                default: ;
            endcase
        end
    end

    // capture the accepted word
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            off_reg   <= in_offset;
            rb_reg    <= in_rb;
            first_reg <= in_first;
        end
    end

    // range checks against the clamped rb count
    always_comb begin
        rb_count = (32'(crbs_reg) > MAX_CORESET_RBS) ? RB_CNT_W'(MAX_CORESET_RBS)
                                                     : RB_CNT_W'(crbs_reg);
        bad_sym  = off_reg >= csyms_reg;
        bad_rb   = 32'(rb_reg) >= 32'(rb_count);
    end

    assign sts.regen     = first_reg && !bad_sym;
    assign sts.err       = bad_sym || bad_rb;
    assign sts.disc_done = disc_cnt_reg == DISC_W'(GOLD_DISCARD);
    assign sts.fill_done = rb_cnt_reg == rb_count;
    assign sts.out_free  = !m_tvalid_reg || m_tready;

    // c_init: symbol term, then product with the odd id term
    always_ff @(posedge aclk) begin
        if (cmd.calc_a) begin
            a_reg <= SYM_A_W'(slot_reg) * SYM_A_W'(SYMS_PER_SLOT)
                   + SYM_A_W'(start_reg) + SYM_A_W'(off_reg) + SYM_A_W'(1);
        end
        if (cmd.calc_p) begin
            p_reg <= CINIT_HI_W'(CINIT_HI_W'(a_reg)
                   * {scr_id_reg[CINIT_HI_W-2:0], 1'b1});
        end
    end

    // one gold step
    always_comb begin
        gold_bit = x1_reg[0] ^ x2_reg[0];
        x1_next  = {x1_reg[0] ^ x1_reg[3], x1_reg[LFSR_W-1:1]};
        x2_next  = {x2_reg[0] ^ x2_reg[1] ^ x2_reg[2] ^ x2_reg[3], x2_reg[LFSR_W-1:1]};
    end

    // lfsrs and step counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x1_reg <= '0;
            x2_reg <= '0;
        end else if (cmd.seed) begin
            x1_reg <= LFSR_W'(1);
            x2_reg <= {p_reg, scr_id_reg, 1'b0};
        end else if (cmd.discard || cmd.fill) begin
            x1_reg <= x1_next;
            x2_reg <= x2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.seed) begin
            disc_cnt_reg <= '0;
            rb_cnt_reg   <= '0;
            bit_cnt_reg  <= '0;
        end else if (cmd.discard) begin
            disc_cnt_reg <= disc_cnt_reg + DISC_W'(1);
        end else if (cmd.fill) begin
            shift_reg <= {gold_bit, shift_reg[BITS_PER_RB-1:1]};
            if (bit_cnt_reg == BIT_CNT_W'(BITS_PER_RB - 1)) begin
                bit_cnt_reg <= '0;
                rb_cnt_reg  <= rb_cnt_reg + RB_CNT_W'(1);
            end else begin
                bit_cnt_reg <= bit_cnt_reg + BIT_CNT_W'(1);
            end
        end
    end

    // store write on the sixth bit of each rb, registered read
    always_ff @(posedge aclk) begin
        if (cmd.fill && bit_cnt_reg == BIT_CNT_W'(BITS_PER_RB - 1)) begin
            store_mem[rb_cnt_reg[RB_ADDR_W-1:0]] <= {gold_bit, shift_reg[BITS_PER_RB-1:1]};
        end
        if (cmd.rd) begin
            rd_word_reg <= store_mem[RB_ADDR_W'(rb_reg)];
        end
    end

    assign re_sel = {cmd.re_idx, 1'b0};

    // output word register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            if (sts.err) begin
                re_reg <= '0;
                im_reg <= '0;
            end else begin
                re_reg <= rd_word_reg[re_sel]                   ? NEG_AMP : POS_AMP;
                im_reg <= rd_word_reg[re_sel + BIT_CNT_W'(1)]   ? NEG_AMP : POS_AMP;
            end
            last_reg <= cmd.re_idx == RE_IDX_W'(RE_PER_RB - 1);
            err_reg  <= sts.err;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {im_reg, re_reg};
    assign m_tlast    = last_reg;
    assign m_tuser[0] = err_reg;

endmodule

// ===== design/pdcch_dmrs_generator.sv =====
// top level of the pdcch dmrs reference symbol generator
//
// Input words name one resource block of a PDCCH candidate and a symbol
// offset in the CORESET; each word yields three QPSK REs of +-23170 (Q15)
// on the output stream, tlast on the third, tuser flagging a range error
// (rb or symbol offset out of range), in which case the REs are zero.
// A word with first_of_symbol set and a valid offset first reseeds the
// Gold generator from c_init, steps it 1600 times and writes 6 bits per
// CORESET RB into a 256 x 6 store, one generator step per cycle.
// A word without regeneration goes through accept, decode, store read and
// three REs before the next acceptance; a range error skips the store read.
// Regeneration adds the c_init, seed, 1600 discard and 6 * min(coreset_rbs, 256)
// fill steps. Without regeneration the first RE follows the store read, or
// the decode for a range error. The config channel is always ready; the user
// must write it only while idle, which the block does not enforce. Reset
// clears the config registers to defaults, the generator and the controller;
// the store content is undefined until first regenerated. A stalled receiver
// holds the output word; the sequencer waits and s_tready stays low until
// the third RE of the word is registered.
module pdcch_dmrs_generator import pdmrs_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input words
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // symbol_offset[1:0], rb_index[9:2], zeros
    input  logic [0:0]            s_tuser,   // first_of_symbol[0]
    // output words
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [2*SAMPLE_W-1:0] m_tdata,   // re_part[15:0], im_part[31:16]
    output logic                  m_tlast,   // last_of_rb
    output logic [0:0]            m_tuser,   // range_error[0]
    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    // sequencer
    pdmrs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    pdmrs_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_offset (s_tdata[OFFSET_W-1:0]),
        .in_rb     (s_tdata[OFFSET_W+RB_IDX_W-1:OFFSET_W]),
        .in_first  (s_tuser[0]),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== design/pdmrs_checker.sv =====
// port-level checks for the dmrs generator, bound to the top level
`include "pdcch_dmrs_generator_assert.svh"

module pdmrs_checker import pdmrs_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [2*SAMPLE_W-1:0] m_tdata,
    input logic                  m_tlast,
    input logic [0:0]            m_tuser
);

    // a stalled output word holds
    `PDMRS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))

    // one word at a time: ready drops right after acceptance
    `PDMRS_ASSERT_NEXT(a_one_word, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // errored words carry zero samples
    `PDMRS_ASSERT_SAME(a_err_zero, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == '0)

    // good words carry only the two qpsk amplitudes
    `PDMRS_ASSERT_SAME(a_qpsk_amp, aclk, aresetn, m_tvalid && !m_tuser[0], (m_tdata[15:0] == POS_AMP || m_tdata[15:0] == NEG_AMP) && (m_tdata[31:16] == POS_AMP || m_tdata[31:16] == NEG_AMP))

endmodule

bind pdcch_dmrs_generator pdmrs_checker u_pdmrs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ===== tb/pdcch_dmrs_generator_tb.sv =====
// self-checking testbench for the pdcch dmrs reference symbol generator
module pdcch_dmrs_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pdmrs_pkg::*;

    localparam int STORE_BITS  = MAX_CORESET_RBS * BITS_PER_RB;
    localparam int HOLD_CYCLES = 300;

    // one output word as seen on the master side
    typedef struct packed {
        logic [SAMPLE_W-1:0] re;
        logic [SAMPLE_W-1:0] im;
        logic                last;
        logic                err;
    } re_word_t;

    // register copies, gold generator, bit store and the queue of due RE words
    class dmrs_re_tracker;
        logic [SCR_ID_W-1:0] scr_id;
        logic [SLOT_W-1:0]   slot_num;
        logic [START_W-1:0]  start_sym;
        logic [CSYM_W-1:0]   n_syms;
        logic [CRBS_W-1:0]   n_rbs;
        logic [LFSR_W-1:0]   x1;
        logic [LFSR_W-1:0]   x2;
        bit                  seq_store [STORE_BITS];
        int unsigned         filled_rbs;
        re_word_t            pending_res[$];
        int unsigned         fails;

        function new();
            scr_id     = '0;
            slot_num   = '0;
            start_sym  = '0;
            n_syms     = 1;
            n_rbs      = 1;
            x1         = '0;
            x2         = '0;
            filled_rbs = 0;
            fails      = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_SCRAMBLING_ID: scr_id    = val[SCR_ID_W-1:0];
                CFG_SLOT_NUMBER:   slot_num  = val[SLOT_W-1:0];
                CFG_START_SYMBOL:  start_sym = val[START_W-1:0];
                CFG_CORESET_SYMS:  n_syms    = val[CSYM_W-1:0];
                CFG_CORESET_RBS:   n_rbs     = val[CRBS_W-1:0];
                default: ;
            endcase
        endfunction

        // rb count clamped to the store size
        function int unsigned active_rbs();
            return (n_rbs > MAX_CORESET_RBS) ? MAX_CORESET_RBS : n_rbs;
        endfunction

        // one step of the length-31 gold sequence
        function bit gold_bit();
            bit c;
            c  = x1[0] ^ x2[0];
            x1 = {x1[0] ^ x1[3], x1[LFSR_W-1:1]};
            x2 = {x2[0] ^ x2[1] ^ x2[2] ^ x2[3], x2[LFSR_W-1:1]};
            return c;
        endfunction

        // c_init, discard run and store fill for a new symbol
        function void reseed_gold(logic [OFFSET_W-1:0] offset);
            logic [63:0] sym;
            logic [63:0] id;
            logic [63:0] slot64;
            logic [63:0] cinit;
            int unsigned n;
            sym    = start_sym;
            sym    = sym + offset;
            id     = scr_id;
            slot64 = slot_num;
            cinit  = (64'd1 << CINIT_SH) * (64'd14 * slot64 + sym + 64'd1) * (64'd2 * id + 64'd1)
                     + 64'd2 * id;
            x1 = 31'd1;
            x2 = cinit[LFSR_W-1:0];
            repeat (GOLD_DISCARD) void'(gold_bit());
            n = active_rbs() * BITS_PER_RB;
            for (int i = 0; i < n; i++) seq_store[i] = gold_bit();
            if (active_rbs() > filled_rbs) filled_rbs = active_rbs();
        endfunction

        // true if the word would read store entries no fill has written
        function bit reads_blank(logic [OFFSET_W-1:0] offset, logic [RB_IDX_W-1:0] rb,
                                 logic first);
            return !first && (offset < n_syms) && (rb < active_rbs()) && (rb >= filled_rbs);
        endfunction

        // accepted input word: queue its three qpsk REs
        function void note_rb_word(logic [OFFSET_W-1:0] offset, logic [RB_IDX_W-1:0] rb,
                                   logic first);
            bit          bad_sym;
            bit          err;
            int unsigned base;
            re_word_t    w;
            bad_sym = offset >= n_syms;
            if (first && !bad_sym) reseed_gold(offset);
            err = bad_sym || (rb >= active_rbs());
            for (int k = 0; k < RE_PER_RB; k++) begin
                base   = rb * BITS_PER_RB + 2 * k;
                w.re   = err ? '0 : (seq_store[base] ? NEG_AMP : POS_AMP);
                w.im   = err ? '0 : (seq_store[base + 1] ? NEG_AMP : POS_AMP);
                w.last = (k == RE_PER_RB - 1);
                w.err  = err;
                pending_res.push_back(w);
            end
        endfunction

        // accepted output word against the oldest due RE
        function void check_re_word(re_word_t got);
            re_word_t want;
            if (pending_res.size() == 0) begin
                fails++;
                if (fails <= 10)
                    $display("unexpected RE word: re %0d im %0d last %0b err %0b",
                             $signed(got.re), $signed(got.im), got.last, got.err);
                return;
            end
            want = pending_res.pop_front();
            if (got.re !== want.re || got.im !== want.im || got.last !== want.last ||
                got.err !== want.err) begin
                fails++;
                if (fails <= 10)
                    $display("RE mismatch: exp re %0d im %0d last %0b err %0b, got re %0d im %0d last %0b err %0b",
                             $signed(want.re), $signed(want.im), want.last, want.err,
                             $signed(got.re), $signed(got.im), got.last, got.err);
            end
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata   = '0;   // symbol_offset[1:0], rb_index[9:2], zeros
    logic [0:0]            s_tuser   = '0;   // first_of_symbol[0]
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [2*SAMPLE_W-1:0] m_tdata;          // re_part[15:0], im_part[31:16]
    logic                  m_tlast;
    logic [0:0]            m_tuser;          // range_error[0]
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    dmrs_re_tracker book = new();
    bit             hold_req = 1'b0;
    bit             no_gaps  = 1'b0;

    pdcch_dmrs_generator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 100 MHz clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // hang guard
    initial begin : watchdog
        #30_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // one register write, valid left high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        book.set_reg(idx, val[CFG_DATA_W-1:0]);
    endtask

    // stop offering and wait for every due RE word
    task automatic drain();
        s_tvalid <= 1'b0;
        while (book.pending_res.size() != 0) @(posedge aclk);
    endtask

    // full register set, written once the block is idle
    task automatic set_config(input int unsigned id, input int unsigned slot,
                              input int unsigned start, input int unsigned syms,
                              input int unsigned rbs);
        drain();
        write_reg(CFG_SCRAMBLING_ID, id);
        write_reg(CFG_SLOT_NUMBER, slot);
        write_reg(CFG_START_SYMBOL, start);
        write_reg(CFG_CORESET_SYMS, syms);
        write_reg(CFG_CORESET_RBS, rbs);
        cfg_valid <= 1'b0;
    endtask

    // one input word; a word that would read an unfilled rb starts a symbol instead
    task automatic send_word(input logic [OFFSET_W-1:0] offset, input logic [RB_IDX_W-1:0] rb,
                             input logic first);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 11);
        if (book.reads_blank(offset, rb, first)) first = 1'b1;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, rb, offset};
        s_tuser  <= first;
        do @(posedge aclk); while (!s_tready);
        book.note_rb_word(offset, rb, first);
    endtask

    // mostly in-range words, symbol starts now and then, some out-of-range noise
    task automatic send_random(input int count);
        int unsigned          eff;
        int unsigned          syms;
        logic [OFFSET_W-1:0]  offset;
        logic [RB_IDX_W-1:0]  rb;
        logic                 first;
        repeat (count) begin
            eff  = book.active_rbs();
            syms = book.n_syms;
            if (syms > 0 && $urandom_range(0, 6) != 0)
                offset = OFFSET_W'($urandom_range(0, syms - 1));
            else offset = OFFSET_W'($urandom_range(0, 3));
            if (eff > 0 && $urandom_range(0, 6) != 0) rb = RB_IDX_W'($urandom_range(0, eff - 1));
            else rb = RB_IDX_W'($urandom_range(0, 255));
            first = ($urandom_range(0, 4) == 0);
            send_word(offset, rb, first);
        end
    endtask

    // random setting, mostly small coresets to keep regeneration short
    task automatic random_phase(input int count, input bit pressure);
        int unsigned rbs;
        case ($urandom_range(0, 9))
            0:       rbs = $urandom_range(0, 511);
            1:       rbs = MAX_CORESET_RBS;
            default: rbs = $urandom_range(1, 24);
        endcase
        set_config($urandom_range(0, 65535), $urandom_range(0, 511), $urandom_range(0, 15),
                   ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3), rbs);
        no_gaps = pressure || ($urandom_range(0, 3) == 0);
        if (pressure) hold_req = 1'b1;
        send_random(count);
    endtask

    // result side: random stalls, calm stretches and one long hold-off
    initial begin : re_sink
        re_word_t got;
        int       stall;
        int       calm;
        calm = 0;
        wait (aresetn === 1'b1);
        forever begin
            if (calm > 0) calm--;
            else if ($urandom_range(0, 29) == 0) calm = $urandom_range(10, 40);
            stall = (calm > 0) ? 0 : $urandom_range(0, 11);
            if (hold_req) begin
                hold_req = 1'b0;
                stall    = HOLD_CYCLES;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got.re   = m_tdata[SAMPLE_W-1:0];
            got.im   = m_tdata[2*SAMPLE_W-1:SAMPLE_W];
            got.last = m_tlast;
            got.err  = m_tuser[0];
            book.check_re_word(got);
        end
    end

    // reset, directed words, random phases, final verdict
    initial begin : stimulus
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // widest setting: rb and offset extremes, bad offset with a symbol start
        set_config(65535, 319, 13, 3, 256);
        send_word(2'd0, 8'd0, 1'b1);
        send_word(2'd0, 8'd255, 1'b0);
        send_word(2'd2, 8'd255, 1'b1);
        send_word(2'd3, 8'd7, 1'b1);
        send_word(2'd1, 8'd128, 1'b0);
        send_word(2'd1, 8'd64, 1'b1);

        // zero symbols: everything out of range
        set_config(0, 0, 0, 0, 0);
        send_word(2'd0, 8'd0, 1'b1);
        send_word(2'd3, 8'd255, 1'b0);

        // zero rbs
        set_config(0, 511, 15, 1, 0);
        send_word(2'd0, 8'd0, 1'b1);
        send_word(2'd0, 8'd1, 1'b0);
        send_word(2'd1, 8'd0, 1'b1);

        // rb count above the store size is clamped
        set_config(43690, 0, 0, 2, 511);
        send_word(2'd1, 8'd255, 1'b1);
        send_word(2'd0, 8'd0, 1'b1);
        send_word(2'd0, 8'd255, 1'b0);
        send_word(2'd1, 8'd100, 1'b0);

        set_config(21845, 170, 5, 3, 257);
        send_word(2'd2, 8'd255, 1'b1);
        send_word(2'd2, 8'd0, 1'b0);

        // one-rb coreset: rb 1 is already out of range
        set_config(1, 1, 0, 1, 1);
        send_word(2'd0, 8'd0, 1'b1);
        send_word(2'd0, 8'd1, 1'b0);
        send_word(2'd0, 8'd0, 1'b0);

        for (int p = 0; p < 8; p++) random_phase(24, p == 2);

        drain();
        repeat (40) @(posedge aclk);
        if (book.pending_res.size() != 0) begin
            $display("%0d RE words never arrived", book.pending_res.size());
            book.fails += book.pending_res.size();
        end
        if (book.fails == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/pdmrs_pkg.sv
design/pdmrs_ctrl.sv
design/pdmrs_datapath.sv
design/pdcch_dmrs_generator.sv
design/pdmrs_checker.sv
tb/pdcch_dmrs_generator_tb.sv
